### sv/otr_pkg.sv
// ----------------------------------------------------------------------------
// otr_pkg: shared types for the overwriting trace ring
// Payload structs for the input and result channels, the stored entry
// layout and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package otr_pkg;

	localparam int unsigned MAX_BURST = 64;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_READ   = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [7:0]         event_kind;
		logic [15:0]        proc_id;
		logic signed [31:0] arg_a;
		logic signed [31:0] arg_b;
		logic signed [31:0] arg_c;
		logic [31:0]        timestamp;
		logic [6:0]         read_limit;
	} in_item_t;

	typedef struct packed {
		logic               empty_res;
		logic               last;
		logic [31:0]        seq_no;
		logic [31:0]        stamp;
		logic [7:0]         kind_out;
		logic [15:0]        pid_out;
		logic signed [31:0] arg_a_out;
		logic signed [31:0] arg_b_out;
		logic signed [31:0] arg_c_out;
		logic [31:0]        lost_out;
	} out_item_t;

	// one ring slot
	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] stamp;
		logic [7:0]  kind;
		logic [15:0] pid;
		logic [31:0] arg_a;
		logic [31:0] arg_b;
		logic [31:0] arg_c;
		logic [31:0] lost;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHOW
	} state_t;

endpackage

`default_nettype wire

### sv/overwriting_trace_ring.sv
// ----------------------------------------------------------------------------
// overwriting_trace_ring: trace event ring that overwrites its oldest entries
// Records go into a DEPTH-entry synchronous RAM; a read request drains up
// to min(read_limit, MAX_BURST) oldest unread entries, one result per entry.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_valid / in_ready  | otr_pkg::in_item_t
//  out     | output    | out_valid / out_ready| otr_pkg::out_item_t
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (trace enable)
//
//  A record transaction's RAM write happens at acceptance.
//  A read transaction is accepted, then each returned entry takes a RAM read
//  (ST_READ), then the registered result (ST_SHOW), which out_ready may stall.
//  A read with nothing to return gives its single empty result in the cycle
//  after acceptance. in_ready is high only while no read burst is in flight.
//  Reset clears the counters and enables tracing; RAM contents are not cleared.
//
`default_nettype none

module overwriting_trace_ring #(
	parameter int unsigned DEPTH = 128
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  otr_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output otr_pkg::out_item_t  out_data,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [31:0] DEPTH32 = 32'(DEPTH);
	localparam logic [6:0] BURST_MAX = 7'(otr_pkg::MAX_BURST);

	otr_pkg::state_t state_q, state_d;

	logic          enable_q;
	logic [31:0]   write_seq_q;
	logic [31:0]   read_seq_q;
	logic [31:0]   lost_count_q;
	logic [AW-1:0] write_slot_q;
	logic [AW-1:0] read_slot_q;
	logic [6:0]    count_q;
	logic          last_q;
	logic          empty_q;

	otr_pkg::entry_t mem_q [DEPTH];
	otr_pkg::entry_t rdata_q;
	otr_pkg::entry_t wdata;

	logic          in_fire;
	logic          out_fire;
	logic          rec_fire;
	logic          rd_fire;
	logic          mem_re;
	logic [31:0]   write_seq_nx;
	logic [AW-1:0] write_slot_nx;
	logic [AW-1:0] read_slot_nx;
	logic [31:0]   avail;
	logic [6:0]    limit;
	logic [6:0]    burst_len;
	logic          burst_none;

	assign cfg_ready = 1'b1;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign rec_fire = in_fire && (in_data.opcode == otr_pkg::OP_RECORD) && enable_q;
	assign rd_fire  = in_fire && (in_data.opcode == otr_pkg::OP_READ);

	// slot follows seq mod DEPTH, including the restart when seq wraps to zero
	assign write_seq_nx  = write_seq_q + 32'd1;
	assign write_slot_nx = (write_seq_q == '1 || write_slot_q == LAST_SLOT) ?
		'0 : write_slot_q + AW'(1);
	assign read_slot_nx  = (read_seq_q == '1 || read_slot_q == LAST_SLOT) ?
		'0 : read_slot_q + AW'(1);

	assign avail      = write_seq_q - read_seq_q;
	assign limit      = (in_data.read_limit > BURST_MAX) ? BURST_MAX : in_data.read_limit;
	assign burst_len  = (avail < 32'(limit)) ? avail[6:0] : limit;
	assign burst_none = (burst_len == 7'd0);

	always_comb begin
		wdata.seq   = write_seq_q;
		wdata.stamp = in_data.timestamp;
		wdata.kind  = in_data.event_kind;
		wdata.pid   = in_data.proc_id;
		wdata.arg_a = in_data.arg_a;
		wdata.arg_b = in_data.arg_b;
		wdata.arg_c = in_data.arg_c;
		wdata.lost  = lost_count_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			otr_pkg::ST_IDLE: begin
				if (rd_fire) begin
					state_d = burst_none ? otr_pkg::ST_SHOW : otr_pkg::ST_READ;
				end
			end
			otr_pkg::ST_READ: begin
				state_d = otr_pkg::ST_SHOW;
			end
			otr_pkg::ST_SHOW: begin
				if (out_fire) begin
					state_d = last_q ? otr_pkg::ST_IDLE : otr_pkg::ST_READ;
				end
			end
			default: begin
				state_d = otr_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		mem_re    = 1'b0;
		unique case (state_q)
			otr_pkg::ST_IDLE: in_ready  = 1'b1;
			otr_pkg::ST_READ: mem_re    = 1'b1;
			otr_pkg::ST_SHOW: out_valid = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= otr_pkg::ST_IDLE;
			enable_q     <= 1'b1;
			write_seq_q  <= '0;
			read_seq_q   <= '0;
			lost_count_q <= '0;
			write_slot_q <= '0;
			read_slot_q  <= '0;
			count_q      <= '0;
			last_q       <= 1'b0;
			empty_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				enable_q <= cfg_data;
			end
			if (rec_fire) begin
				write_seq_q  <= write_seq_nx;
				write_slot_q <= write_slot_nx;
				// writer lapped the reader: drop the oldest entry
				if ((write_seq_nx - read_seq_q) > DEPTH32) begin
					read_seq_q   <= write_seq_nx - DEPTH32;
					read_slot_q  <= write_slot_nx;
					lost_count_q <= lost_count_q + 32'd1;
				end
			end
			if (rd_fire) begin
				count_q <= burst_len;
				empty_q <= burst_none;
				last_q  <= burst_none;
			end
			if (mem_re) begin
				read_seq_q  <= read_seq_q + 32'd1;
				read_slot_q <= read_slot_nx;
				count_q     <= count_q - 7'd1;
				last_q      <= (count_q == 7'd1);
			end
		end
	end

	// ring storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (rec_fire) begin
			mem_q[write_slot_q] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[read_slot_q];
		end
	end

	always_comb begin
		if (empty_q) begin
			out_data           = '0;
			out_data.empty_res = 1'b1;
			out_data.last      = 1'b1;
		end else begin
			out_data.empty_res = 1'b0;
			out_data.last      = last_q;
			out_data.seq_no    = rdata_q.seq;
			out_data.stamp     = rdata_q.stamp;
			out_data.kind_out  = rdata_q.kind;
			out_data.pid_out   = rdata_q.pid;
			out_data.arg_a_out = rdata_q.arg_a;
			out_data.arg_b_out = rdata_q.arg_b;
			out_data.arg_c_out = rdata_q.arg_c;
			out_data.lost_out  = rdata_q.lost;
		end
	end

endmodule

`default_nettype wire

### sv/otr_checker.sv
// ----------------------------------------------------------------------------
// otr_checker: port-level checks for the overwriting trace ring
// Watches the channel handshakes and the result payload over time.
// ----------------------------------------------------------------------------
`default_nettype none

module otr_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_ready,
	input otr_pkg::in_item_t  in_data,
	input wire                out_valid,
	input wire                out_ready,
	input otr_pkg::out_item_t out_data
);

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no new request is taken while a result is pending
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	// an empty result always closes its burst and carries no entry
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_res |->
			out_data.last && out_data.seq_no == 32'd0 && out_data.lost_out == 32'd0)
		else $error("malformed empty result");

	// a read request starts a burst: in_ready is low in the cycle after acceptance
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == otr_pkg::OP_READ |=>
			!in_ready)
		else $error("read request did not start a burst");

endmodule

bind overwriting_trace_ring otr_checker u_otr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
